// ----- hdl/mve_pkg.sv -----
// package for the msb-first varint encoder
// holds widths, the mode code and the sequencer state type; no dependencies
`default_nettype none

package mve_pkg;

    localparam int IN_VALUE_W          = 64;
    localparam int BYTE_W              = 8;
    localparam int GROUP_W             = 7;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/mve_if.sv -----
// valid/ready channel interfaces for the msb-first varint encoder
// depends on mve_pkg for payload widths
`default_nettype none

interface mve_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [mve_pkg::IN_VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mve_out_if;
    logic                       valid;
    logic                       ready;
    logic [mve_pkg::BYTE_W-1:0] out_byte;
    logic                       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/msb_first_varint_encoder_top.sv -----
// top level of the msb-first base-128 varint encoder
// depends on mve_pkg, mve_in_if, mve_out_if and mve_mag
`default_nettype none

// One item enters when the block is idle. Its word, padded to NG = ceil(VALUE_WIDTH/7)
// groups of 7 bits, goes into one shift register; a 7-bit shifter then drops leading zero
// groups one per cycle, then sends one byte per cycle from the top group while the output
// register is free; an output stall holds the byte. A new item is taken only once the
// last group of the item before it has been loaded into the output register.
// The last byte waits in the output register while the next item is accepted.
module msb_first_varint_encoder_top #(
    parameter int VALUE_WIDTH = mve_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mve_in_if.sink    i_in,
    mve_out_if.source o_out
);
    import mve_pkg::*;

    localparam int NG = (VALUE_WIDTH + GROUP_W - 1) / GROUP_W;
    localparam int SW = NG * GROUP_W;
    localparam int CW = $clog2(NG + 1);

    t_state              r_state;
    t_state              n_state;
    logic [SW-1:0]       r_sh;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic [VALUE_WIDTH-1:0] w_word;
    logic [GROUP_W-1:0]     w_top;
    logic                   w_is_last;
    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_skip;
    logic                   w_load;

    mve_mag #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_mag (
        .i_op   (i_in.op),
        .i_value(i_in.value[VALUE_WIDTH-1:0]),
        .o_word (w_word)
    );

    assign w_top      = r_sh[SW-1 -: GROUP_W];
    assign w_is_last  = (r_cnt == CW'(1));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // input ready, group skip and byte load decode
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        w_skip     = (r_state == ST_SCAN) && (w_top == '0) && !w_is_last;
        w_load     = ((r_state == ST_SCAN) || (r_state == ST_EMIT)) && !w_skip && w_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_load) begin
                    n_state = w_is_last ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && w_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_cnt <= CW'(NG);
            end else if (w_skip || w_load) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sh <= SW'(w_word);
        end else if (w_skip || w_load) begin
            r_sh <= r_sh << GROUP_W;
        end
        if (w_load) begin
            r_out_byte <= {!w_is_last, w_top};
            r_out_last <= w_is_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_cnt == CW'(NG)))
        else $error("accepted item did not start a scan");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt != '0))
        else $error("group count ran out while busy");

    a_flag_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_byte[BYTE_W-1] != r_out_last))
        else $error("continuation bit disagrees with last");

    a_final_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_is_last) |=> (r_state == ST_IDLE) && r_out_last)
        else $error("final byte did not end the item");

endmodule

`default_nettype wire

// ----- hdl/mve_mag.sv -----
// magnitude preparation: turns an input value into the bit word that is cut into groups
// signed mode gives {magnitude, sign}; depends on mve_pkg
`default_nettype none

module mve_mag #(
    parameter int VALUE_WIDTH = mve_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   i_op,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic      [VALUE_WIDTH-1:0] o_word
);
    import mve_pkg::*;

    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_min;
    logic [VALUE_WIDTH-1:0] w_mag;

    assign w_neg = (i_op == OP_SIGNED) && i_value[VALUE_WIDTH-1];
    assign w_min = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    always_comb begin
        if (!w_neg) begin
            w_mag = i_value;
        end else if (i_value == w_min) begin
            w_mag = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            w_mag = (~i_value) + VALUE_WIDTH'(1);
        end
    end

    always_comb begin
        if (i_op == OP_SIGNED) begin
            o_word = {w_mag[VALUE_WIDTH-2:0], w_neg};
        end else begin
            o_word = i_value;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_msb_first_varint_encoder_top.sv -----
// testbench for msb_first_varint_encoder_top: a directed table, then random values, under three
// handshake pacing phases; each output byte is checked against its table row or an in-bench encoder
// depends on mve_pkg, mve_in_if, mve_out_if and the encoder rtl
`default_nettype none

module tb_msb_first_varint_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mve_pkg::*;

    localparam int VW          = DEFAULT_VALUE_WIDTH;
    localparam int MAX_BYTES   = 10;
    localparam int RAND_ITEMS  = 207;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_enc_byte;

    typedef struct {
        logic                  op;
        logic [IN_VALUE_W-1:0] value;
        int                    nbytes;
        logic [79:0]           bytes;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mve_in_if  in_if ();
    mve_out_if out_if ();

    msb_first_varint_encoder_top #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_enc_byte encoded_bytes_due [$];
    t_row      table_rows [$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        mismatches;
    int        bytes_checked;
    int        items_sent;
    int        cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void queue_expected_byte(input logic [7:0] b, input logic is_last);
        t_enc_byte e;
        e.out_byte = b;
        e.last     = is_last;
        encoded_bytes_due.insert(encoded_bytes_due.size(), e);
    endfunction

    function automatic void predict_encoding(input logic op, input logic [IN_VALUE_W-1:0] raw);
        logic [63:0] mask;
        logic [63:0] sign;
        logic [63:0] v;
        logic [63:0] mag;
        logic [6:0]  groups [MAX_BYTES];
        logic [7:0]  b;
        logic        neg;
        int          n;
        mask = {64{1'b1}} >> (64 - VW);
        sign = 64'd1 << (VW - 1);
        v    = raw & mask;
        neg  = 1'b0;
        if (op == OP_UNSIGNED) begin
            mag       = v;
            groups[0] = mag[6:0];
            mag       = mag >> 7;
        end else begin
            neg = (v & sign) != 64'd0;
            if (neg) begin
                v = v | ~mask;
                if (v == (sign | ~mask)) begin
                    v = v + 64'd1;
                end
                mag = 64'd0 - v;
            end else begin
                mag = v;
            end
            groups[0] = {1'b0, mag[5:0]};
            mag       = mag >> 6;
        end
        n = 1;
        while (mag != 64'd0 && n < MAX_BYTES) begin
            groups[n] = mag[6:0];
            mag       = mag >> 7;
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (i > 0) begin
                b = {1'b1, groups[i]};
            end else if (op == OP_SIGNED) begin
                b = {1'b0, groups[0][5:0], neg};
            end else begin
                b = {1'b0, groups[0]};
            end
            queue_expected_byte(b, (i == 0));
        end
    endfunction

    // nbytes of zero means the row is checked against the predictor
    function automatic void add_row(input logic op, input logic [63:0] value, input int nbytes,
                                    input logic [79:0] bytes);
        t_row r;
        r.op     = op;
        r.value  = value;
        r.nbytes = nbytes;
        r.bytes  = bytes;
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic logic [63:0] random_value(input logic op);
        logic [63:0] raw;
        int          w;
        int          pick;
        pick = $urandom_range(0, 19);
        raw  = {$urandom, $urandom};
        if (pick == 0) begin
            raw = 64'h8000_0000_0000_0000;
        end else if (pick == 1) begin
            raw = {64{1'b1}};
        end else if (pick == 2) begin
            raw = 64'd1 << $urandom_range(0, 63);
        end else if (pick < 12) begin
            w = $urandom_range(0, 63);
            raw = raw & ((64'd1 << w) - 64'd1);
            if (op == OP_SIGNED && $urandom_range(0, 1) == 1) begin
                raw = 64'd0 - raw;
            end
        end
        return raw;
    endfunction

    task automatic send_item(input logic op, input logic [63:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.op    <= 1'($urandom_range(0, 1));
            in_if.value <= {$urandom, $urandom};
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= value;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (encoded_bytes_due.size() == 0) begin
                $error("unexpected byte: out_byte %02h last %0b", out_if.out_byte, out_if.last);
                mismatches++;
            end else begin
                t_enc_byte want;
                want = encoded_bytes_due.pop_front();
                bytes_checked++;
                if (out_if.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, out_if.out_byte);
                    mismatches++;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_if.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic op;
        in_if.valid   = 1'b0;
        in_if.op      = OP_UNSIGNED;
        in_if.value   = '0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 80;
        mismatches    = 0;
        bytes_checked = 0;
        items_sent    = 0;
        cycle_count   = 0;

        add_row(OP_UNSIGNED, 64'd0,   1, {8'h00, 72'h0});
        add_row(OP_UNSIGNED, 64'd1,   1, {8'h01, 72'h0});
        add_row(OP_UNSIGNED, 64'd127, 1, {8'h7f, 72'h0});
        add_row(OP_UNSIGNED, 64'd128, 2, {16'h8100, 64'h0});
        add_row(OP_UNSIGNED, {64{1'b1}}, 10, 80'h81ff_ffff_ffff_ffff_ff7f);
        add_row(OP_UNSIGNED, 64'h8000_0000_0000_0000, 0, '0);
        add_row(OP_UNSIGNED, 64'h7fff_ffff_ffff_ffff, 0, '0);
        add_row(OP_UNSIGNED, 64'h0100_0000_0000_0000, 0, '0);
        add_row(OP_UNSIGNED, 64'h5555_5555_5555_5555, 0, '0);
        add_row(OP_UNSIGNED, 64'haaaa_aaaa_aaaa_aaaa, 0, '0);
        add_row(OP_SIGNED,   64'd0,   1, {8'h00, 72'h0});
        add_row(OP_SIGNED,   64'd1,   1, {8'h02, 72'h0});
        add_row(OP_SIGNED,   {64{1'b1}}, 1, {8'h03, 72'h0});
        add_row(OP_SIGNED,   64'd63,  1, {8'h7e, 72'h0});
        add_row(OP_SIGNED,   64'd64,  2, {16'h8100, 64'h0});
        add_row(OP_SIGNED,   64'd0 - 64'd63, 1, {8'h7f, 72'h0});
        add_row(OP_SIGNED,   64'd0 - 64'd64, 2, {16'h8101, 64'h0});
        add_row(OP_SIGNED,   64'h7fff_ffff_ffff_ffff, 10, 80'h81ff_ffff_ffff_ffff_ff7e);
        // most negative saturates to most negative plus one
        add_row(OP_SIGNED,   64'h8000_0000_0000_0000, 10, 80'h81ff_ffff_ffff_ffff_ff7f);
        add_row(OP_SIGNED,   64'h8000_0000_0000_0001, 10, 80'h81ff_ffff_ffff_ffff_ff7f);
        add_row(OP_SIGNED,   64'h1234_5678_9abc_def0, 0, '0);
        add_row(OP_SIGNED,   64'hfedc_ba98_7654_3210, 0, '0);
        add_row(OP_SIGNED,   64'h5555_5555_5555_5555, 0, '0);
        add_row(OP_SIGNED,   64'haaaa_aaaa_aaaa_aaaa, 0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (table_rows[r]) begin
            if (table_rows[r].nbytes == 0) begin
                predict_encoding(table_rows[r].op, table_rows[r].value);
            end else begin
                for (int k = 0; k < table_rows[r].nbytes; k++) begin
                    queue_expected_byte(table_rows[r].bytes[79-8*k -: 8],
                                        (k == table_rows[r].nbytes - 1));
                end
            end
            send_item(table_rows[r].op, table_rows[r].value);
        end

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 80;
                recv_idle_pct = 10;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RAND_ITEMS / 3) begin
                logic [63:0] value;
                op    = 1'($urandom_range(0, 1));
                value = random_value(op);
                predict_encoding(op, value);
                send_item(op, value);
            end
        end

        in_if.valid <= 1'b0;
        while (encoded_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * MAX_BYTES) @(posedge i_clk);

        $display("%0d items encoded, %0d bytes checked", items_sent, bytes_checked);
        $display("directed table plus random values, signed and unsigned, three pacing phases");
        if (mismatches == 0 && encoded_bytes_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (encoded_bytes_due.size() != 0) begin
                $error("%0d expected bytes never arrived", encoded_bytes_due.size());
            end
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
